[hdl/rlfr_pkg.sv]
// ----------------------------------------------------------------------------
// rlfr_pkg - radio link frame receiver package
// Word types, classification codes and constants shared by the receiver.
// ----------------------------------------------------------------------------
package rlfr_pkg;

    localparam int MAX_FRAME   = 256;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] FRAME_LAST  = 8'(MAX_FRAME - 1);

    localparam logic [7:0] TAIL_BYTE   = 8'h90;
    localparam logic [7:0] STATUS_HEAD = 8'hEB;
    localparam logic [7:0] RTK_HEAD    = 8'hAC;
    localparam logic [7:0] CR_BYTE     = 8'h0D;
    localparam logic [7:0] LF_BYTE     = 8'h0A;
    localparam logic [7:0] CHAR_O      = 8'h4F;
    localparam logic [7:0] CHAR_K      = 8'h4B;
    localparam logic [7:0] CHAR_E      = 8'h45;
    localparam logic [7:0] CHAR_R      = 8'h52;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_STATUS   = 3'd1;
    localparam logic [2:0] EV_RTK      = 3'd2;
    localparam logic [2:0] EV_OTHER    = 3'd3;
    localparam logic [2:0] EV_MODEM    = 3'd4;
    localparam logic [2:0] EV_DISCARD  = 3'd5;
    localparam logic [2:0] EV_OVERFLOW = 3'd6;

    localparam logic [1:0] REPLY_NONE  = 2'd0;
    localparam logic [1:0] REPLY_READ  = 2'd1;
    localparam logic [1:0] REPLY_ERRO  = 2'd2;

    localparam logic       KIND_BYTE   = 1'b0;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_STATUS,
        CMD_RTK,
        CMD_OTHER,
        CMD_MODEM,
        CMD_DISCARD,
        CMD_OVERFLOW
    } rlfr_op_t;

    typedef enum logic [1:0] {
        RTK_KEEP,
        RTK_SET,
        RTK_CLEAR
    } rlfr_rtk_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] reply_count;
        logic       send_ready;
    } rlfr_in_t;

    typedef struct packed {
        logic [2:0] frame_event;
        logic [7:0] frame_length;
        logic       link_ok;
        logic       rtk_ok;
        logic [1:0] reply_sent;
        logic [7:0] replies_left;
    } rlfr_out_t;

    typedef struct packed {
        rlfr_op_t   op;
        logic [7:0] length;
        logic       link_match;
        rlfr_rtk_t  rtk;
        logic [7:0] reply_count;
        logic       send_ready;
    } rlfr_cmd_t;

endpackage

[hdl/rlfr_front.sv]
// ----------------------------------------------------------------------------
// rlfr_front - byte classifier
// Tracks frame position, header and last two bytes; issues one command word
// per accepted input word.
// ----------------------------------------------------------------------------
module rlfr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  rlfr_pkg::rlfr_in_t item,
    output logic              cmd_push,
    input  logic              cmd_full,
    output rlfr_pkg::rlfr_cmd_t cmd
);
    import rlfr_pkg::*;

    logic [7:0]  count_reg, count_next;
    logic [31:0] header_reg, header_next;
    logic [15:0] last_reg, last_next;

    logic [31:0] header_upd;
    logic [7:0]  b;
    logic [7:0]  p;
    logic [7:0]  prev1;
    logic [7:0]  prev2;

    assign item_ready = !cmd_full;
    assign cmd_push   = item_valid && !cmd_full;

    assign b     = item.data_byte;
    assign p     = count_reg;
    assign prev1 = last_reg[7:0];
    assign prev2 = last_reg[15:8];

    always_comb
    begin
        header_upd = header_reg;
        if (p == 8'd0)
        begin
            header_upd = {24'd0, b};
        end
        else if (p < 8'd4)
        begin
            header_upd[{p[1:0], 3'b000} +: 8] = b;
        end
    end

    always_comb
    begin
        count_next       = count_reg;
        header_next      = header_reg;
        last_next        = last_reg;
        cmd.op           = CMD_NONE;
        cmd.length       = 8'd0;
        cmd.link_match   = 1'b0;
        cmd.rtk          = RTK_KEEP;
        cmd.reply_count  = item.reply_count;
        cmd.send_ready   = item.send_ready;
        if (item.kind != KIND_BYTE)
        begin
            cmd.op = CMD_LOAD;
        end
        else
        begin
            priority if (b == TAIL_BYTE)
            begin
                cmd.length = p;
                if (header_upd[7:0] == STATUS_HEAD)
                begin
                    cmd.op         = CMD_STATUS;
                    cmd.link_match = (p >= 8'd2) && (prev2 == CHAR_O) && (prev1 == CHAR_K);
                end
                else if (header_upd[7:0] == RTK_HEAD)
                begin
                    cmd.op = CMD_RTK;
                    if ((p >= 8'd3) && (header_upd[15:8] == CHAR_O)
                        && (header_upd[23:16] == CHAR_K))
                    begin
                        cmd.rtk = RTK_SET;
                    end
                    else if ((p >= 8'd4) && (header_upd[15:8] == CHAR_E)
                        && (header_upd[23:16] == CHAR_R) && (header_upd[31:24] == CHAR_R))
                    begin
                        cmd.rtk = RTK_CLEAR;
                    end
                end
                else
                begin
                    cmd.op = CMD_OTHER;
                end
                count_next  = 8'd0;
                header_next = 32'd0;
                last_next   = 16'd0;
            end
            else if ((p >= 8'd2) && (prev2 == CHAR_K) && (prev1 == CR_BYTE) && (b == LF_BYTE))
            begin
                cmd.length  = p;
                cmd.op      = (header_upd[7:0] == CHAR_PLUS) ? CMD_MODEM : CMD_DISCARD;
                count_next  = 8'd0;
                header_next = 32'd0;
                last_next   = 16'd0;
            end
            else if (p >= FRAME_LAST)
            begin
                cmd.length  = p;
                cmd.op      = CMD_OVERFLOW;
                count_next  = 8'd0;
                header_next = 32'd0;
                last_next   = 16'd0;
            end
            else
            begin
                count_next  = p + 8'd1;
                header_next = header_upd;
                last_next   = {prev1, b};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 8'd0;
            header_reg <= 32'd0;
            last_reg   <= 16'd0;
        end
        else if (cmd_push)
        begin
            count_reg  <= count_next;
            header_reg <= header_next;
            last_reg   <= last_next;
        end
    end

endmodule

[hdl/rlfr_queue.sv]
// ----------------------------------------------------------------------------
// rlfr_queue - command queue
// Short FIFO of command words between classifier and executor.
// ----------------------------------------------------------------------------
module rlfr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rlfr_pkg::rlfr_cmd_t cmd_in,
    output logic                full,
    input  logic                pop,
    output rlfr_pkg::rlfr_cmd_t cmd_out,
    output logic                empty
);
    import rlfr_pkg::*;

    rlfr_cmd_t entry_reg [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;

    assign full    = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign cmd_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[hdl/rlfr_back.sv]
// ----------------------------------------------------------------------------
// rlfr_back - command executor
// Applies command words to link, RTK and reply state; holds the result word.
// ----------------------------------------------------------------------------
module rlfr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  rlfr_pkg::rlfr_cmd_t cmd,
    input  logic                cmd_empty,
    output logic                cmd_pop,
    output logic                result_valid,
    input  logic                result_ready,
    output rlfr_pkg::rlfr_out_t result
);
    import rlfr_pkg::*;

    logic       link_reg, link_next;
    logic       rtk_reg, rtk_next;
    logic [7:0] pending_reg, pending_next;
    logic       flag_reg, flag_next;
    logic       valid_reg;
    rlfr_out_t  result_reg, result_next;

    assign cmd_pop      = !cmd_empty && (!valid_reg || result_ready);
    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        link_next    = link_reg;
        rtk_next     = rtk_reg;
        pending_next = pending_reg;
        flag_next    = flag_reg;
        result_next.frame_event  = EV_NONE;
        result_next.frame_length = cmd.length;
        result_next.reply_sent   = REPLY_NONE;
        unique case (cmd.op)
            CMD_NONE:
            begin
                result_next.frame_length = 8'd0;
            end
            CMD_LOAD:
            begin
                result_next.frame_length = 8'd0;
                pending_next             = cmd.reply_count;
                flag_next                = cmd.send_ready;
            end
            CMD_STATUS:
            begin
                result_next.frame_event = EV_STATUS;
                link_next               = cmd.link_match;
                if (pending_reg != 8'd0)
                begin
                    result_next.reply_sent = flag_reg ? REPLY_READ : REPLY_ERRO;
                    pending_next           = pending_reg - 8'd1;
                end
            end
            CMD_RTK:
            begin
                result_next.frame_event = EV_RTK;
                unique case (cmd.rtk)
                    RTK_SET:   rtk_next = 1'b1;
                    RTK_CLEAR: rtk_next = 1'b0;
                    default:   rtk_next = rtk_reg;
                endcase
            end
            CMD_OTHER:    result_next.frame_event = EV_OTHER;
            CMD_MODEM:    result_next.frame_event = EV_MODEM;
            CMD_DISCARD:  result_next.frame_event = EV_DISCARD;
            CMD_OVERFLOW: result_next.frame_event = EV_OVERFLOW;
            default:      result_next.frame_length = 8'd0;
        endcase
        result_next.link_ok      = link_next;
        result_next.rtk_ok       = rtk_next;
        result_next.replies_left = pending_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg    <= 1'b0;
            rtk_reg     <= 1'b0;
            pending_reg <= 8'd0;
            flag_reg    <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                link_reg    <= link_next;
                rtk_reg     <= rtk_next;
                pending_reg <= pending_next;
                flag_reg    <= flag_next;
                valid_reg   <= 1'b1;
            end
            else if (result_ready)
            begin
                valid_reg   <= 1'b0;
            end
        end
    end

endmodule

[hdl/radio_link_frame_receiver.sv]
// ----------------------------------------------------------------------------
// radio_link_frame_receiver - radio link frame receiver
// Takes one word per cycle (a received byte or a reply setting) while the
// command queue has room, and returns one result word per input word: frame
// event, length, link/RTK state and reply signalling. An accepted word goes
// into the command queue, then is registered as the result word when the
// output side is free. One word per cycle is sustained while neither side
// stalls; a two-word queue between classifier and executor lets either stall.
// ----------------------------------------------------------------------------
module radio_link_frame_receiver (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  rlfr_pkg::rlfr_in_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output rlfr_pkg::rlfr_out_t result
);
    import rlfr_pkg::*;

    rlfr_cmd_t cmd_in;
    rlfr_cmd_t cmd_out;
    logic      cmd_push;
    logic      cmd_full;
    logic      cmd_pop;
    logic      cmd_empty;

    rlfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_push   (cmd_push),
        .cmd_full   (cmd_full),
        .cmd        (cmd_in)
    );

    rlfr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .cmd_in  (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .cmd_out (cmd_out),
        .empty   (cmd_empty)
    );

    rlfr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_out),
        .cmd_empty    (cmd_empty),
        .cmd_pop      (cmd_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
